FILE: design/rcst_pkg.sv
// shared constants and types for the roi color statistics threshold block
package rcst_pkg;
  localparam int ImageWidth  = 640;
  localparam int ImageHeight = 480;
  localparam logic [18:0] CountMax = 19'h7FFFF;
  localparam logic [2:0] RegAx   = 3'd0;
  localparam logic [2:0] RegAy   = 3'd1;
  localparam logic [2:0] RegBx   = 3'd2;
  localparam logic [2:0] RegBy   = 3'd3;
  localparam logic [2:0] RegPrec = 3'd4;
  localparam logic [11:0] HueClamp = 12'd2864;
  localparam logic [11:0] ChanClamp = 12'd4080;
  typedef logic [11:0] thr_t;
endpackage

FILE: design/roi_color_stats_threshold_top.sv
// roi color statistics and mean +/- k*sigma threshold block
// usage:
//   s_axis carries one pixel per beat: tdata holds x, y, hue, sat, val,
//   tlast marks the last pixel of a frame. pixels inside the frame and the
//   inclusive window spanned by the two corner registers are accumulated.
//   pixels are accumulated one per cycle, back to back, while the block is idle.
//   on the tlast beat the block drops tready and runs its statistics
//   sequencer: per channel a 43 step shared restoring divider for the mean,
//   an operand capture step for the multiply, a dividend load step that forms
//   the product, 43 divider steps for the variance, 12 square root steps plus
//   a closing step, and a threshold step. the result beat comes up after the
//   third channel is done and tready returns with it. an empty window skips
//   the sequencer and goes straight to the output state with zero thresholds.
//   m_axis then carries one result beat with the six thresholds in tdata
//   and the empty flag in tuser; it holds until taken. a stalled receiver
//   only holds the sequencer at its end; pixel beats keep flowing meanwhile
//   until the next frame is finished.
//   cfg writes registers by index, always ready; write only while idle.
//   reset (rst, synchronous) clears the statistics and the registers,
//   precision goes to 1.0.
module roi_color_stats_threshold_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // pixel_x[9:0], pixel_y[18:10], hue[26:19], sat[34:27], val[42:35]
  input  logic [47:0] s_axis_tdata,
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // hue_min, hue_max, sat_min, sat_max, val_min, val_max, 12 bits each
  output logic [71:0] m_axis_tdata,
  // window_empty
  output logic        m_axis_tuser,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [9:0]  cfg_data
);
  import rcst_pkg::*;

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StDiv1 = 3'd1;
  localparam logic [2:0] StMul  = 3'd2;
  localparam logic [2:0] StDiv2 = 3'd3;
  localparam logic [2:0] StSqrt = 3'd4;
  localparam logic [2:0] StFin  = 3'd5;
  localparam logic [2:0] StOut  = 3'd6;

  logic [2:0] state;
  logic [9:0] ax, bx;
  logic [8:0] ay, by;
  logic [7:0] prec;
  logic [18:0] cnt;
  logic [26:0] sum [3];
  logic [34:0] sq [3];
  logic [1:0] ch;
  logic [42:0] dreg;
  logic [19:0] rreg;
  logic [5:0] step;
  logic [7:0] mreg;
  logic [18:0] rem;
  logic [23:0] sv, sres, sbit;
  thr_t thr [6];
  logic empty;

  logic [9:0] px, x0, x1;
  logic [8:0] py, y0, y1;
  logic [7:0] pc [3];
  logic in_win, s_acc;
  logic out_load;
  logic [18:0] cnt_next;
  logic [19:0] rs;
  logic ge;
  logic [26:0] csum;
  logic [34:0] csq;
  logic [35:0] prod;
  logic [34:0] qv;
  logic [24:0] sq_try;
  logic [19:0] tt;
  logic [15:0] cc;
  logic [20:0] hi;
  logic [15:0] lo;
  thr_t hi_t, lo_t;

  assign px = s_axis_tdata[9:0];
  assign py = s_axis_tdata[18:10];
  assign pc[0] = s_axis_tdata[26:19];
  assign pc[1] = s_axis_tdata[34:27];
  assign pc[2] = s_axis_tdata[42:35];
  assign x0 = (ax < bx) ? ax : bx;
  assign x1 = (ax < bx) ? bx : ax;
  assign y0 = (ay < by) ? ay : by;
  assign y1 = (ay < by) ? by : ay;
  assign in_win = (px < 10'(ImageWidth)) && (py < 9'(ImageHeight)) &&
                  (px >= x0) && (px <= x1) && (py >= y0) && (py <= y1) &&
                  (cnt < CountMax);
  assign s_axis_tready = (state == StIdle);
  assign s_acc = s_axis_tvalid && s_axis_tready;
  assign out_load = (state == StOut) && (!m_axis_tvalid || m_axis_tready);
  assign cnt_next = in_win ? cnt + 19'd1 : cnt;
  assign cfg_ready = 1'b1;

  assign rs = {rreg[18:0], dreg[42]};
  assign ge = rs >= {1'b0, cnt};
  assign csum = sum[ch];
  assign csq = sq[ch];
  // Q = sumsq - m*(sum + r), r being the remainder of sum/n
  assign prod = 36'(mreg) * (36'(csum) + 36'(rem));
  assign qv = 35'(csq - prod);
  assign sq_try = {1'b0, sres} + {1'b0, sbit};
  assign tt = prec * sres[11:0];
  assign cc = {mreg, 8'd0};
  assign hi = {5'd0, cc} + {1'b0, tt};
  assign lo = 16'({4'd0, cc} - tt);
  assign lo_t = ({4'd0, cc} < tt) ? 12'd0 : lo[15:4];
  assign hi_t = (hi > 21'd65280) ? ((ch == 2'd0) ? HueClamp : ChanClamp) : hi[15:4];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= StIdle;
      ax <= '0; ay <= '0; bx <= '0; by <= '0;
      prec <= 8'd16;
      cnt <= '0;
      for (int i = 0; i < 3; i++) begin
        sum[i] <= '0;
        sq[i] <= '0;
      end
      m_axis_tvalid <= 1'b0;
      ch <= '0;
    end else begin
      if (out_load) begin
        m_axis_tvalid <= 1'b1;
        m_axis_tdata <= {thr[5], thr[4], thr[3], thr[2], thr[1], thr[0]};
        m_axis_tuser <= empty;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      if (cfg_valid) begin
        unique case (cfg_index)
          RegAx: ax <= cfg_data;
          RegAy: ay <= cfg_data[8:0];
          RegBx: bx <= cfg_data;
          RegBy: by <= cfg_data[8:0];
          RegPrec: prec <= cfg_data[7:0];
          default: ;
        endcase
      end
      unique case (state)
        StIdle: begin
          if (s_acc) begin
            if (in_win) begin
              cnt <= cnt_next;
              for (int i = 0; i < 3; i++) begin
                sum[i] <= sum[i] + 27'(pc[i]);
                sq[i] <= sq[i] + 35'(16'(pc[i]) * 16'(pc[i]));
              end
            end
            if (s_axis_tlast) begin
              ch <= '0;
              empty <= (cnt_next == '0);
              dreg <= 43'(sum[0] + (in_win ? 27'(pc[0]) : 27'd0));
              rreg <= '0;
              step <= 6'd43;
              state <= (cnt_next == '0) ? StOut : StDiv1;
              if (cnt_next == '0) begin
                for (int i = 0; i < 6; i++) thr[i] <= '0;
              end
            end
          end
        end
        StDiv1, StDiv2: begin
          if (state == StDiv2 && step == 6'd63) begin
            // product is in place now: load the variance dividend
            dreg <= {qv, 8'd0};
            rreg <= '0;
            step <= 6'd43;
          end else begin
            rreg <= ge ? rs - {1'b0, cnt} : rs;
            dreg <= {dreg[41:0], ge};
            step <= step - 6'd1;
            if (step == 6'd1) begin
              if (state == StDiv1) begin
                state <= StMul;
              end else begin
                state <= StSqrt;
                sv <= {dreg[22:0], ge};
                sres <= '0;
                sbit <= 24'h400000;
              end
            end
          end
        end
        StMul: begin
          mreg <= dreg[7:0];
          rem <= rreg[18:0];
          state <= StDiv2;
          // rem not yet in place: finish the product next cycle
          step <= 6'd63;
        end
        StSqrt: begin
          if (sbit != '0) begin
            if ({1'b0, sv} >= sq_try) begin
              sv <= 24'({1'b0, sv} - sq_try);
              sres <= (sres >> 1) + sbit;
            end else begin
              sres <= sres >> 1;
            end
            sbit <= sbit >> 2;
          end else begin
            state <= StFin;
          end
        end
        StFin: begin
          thr[{ch, 1'b0}] <= lo_t;
          thr[{ch, 1'b1}] <= hi_t;
          if (ch == 2'd2) begin
            state <= StOut;
          end else begin
            ch <= ch + 2'd1;
            dreg <= 43'(sum[ch + 2'd1]);
            rreg <= '0;
            step <= 6'd43;
            state <= StDiv1;
          end
        end
        StOut: begin
          if (out_load) begin
            cnt <= '0;
            for (int i = 0; i < 3; i++) begin
              sum[i] <= '0;
              sq[i] <= '0;
            end
            state <= StIdle;
          end
        end
        default: state <= StIdle;
      endcase
    end
  end
endmodule

FILE: tb/testbench.sv
// self-checking testbench for the roi color statistics threshold block
`timescale 1ns / 1ps

module testbench;
  import rcst_pkg::*;

  localparam logic [2:0] RegNone = 3'd7;

  typedef struct {
    logic [9:0] x;
    logic [8:0] y;
    logic [7:0] h;
    logic [7:0] s;
    logic [7:0] v;
    logic       last;
  } pixel_t;

  typedef struct {
    thr_t thr[6];
    logic empty;
  } stats_t;

  typedef struct {
    logic [2:0] idx;
    logic [9:0] data;
  } cfg_row_t;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  // pixel_x[9:0], pixel_y[18:10], hue[26:19], sat[34:27], val[42:35]
  logic [47:0] s_axis_tdata;
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  // hue_min, hue_max, sat_min, sat_max, val_min, val_max, 12 bits each
  logic [71:0] m_axis_tdata;
  // window_empty
  logic        m_axis_tuser;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [9:0]  cfg_data;

  roi_color_stats_threshold_top dut (.*);

  // predictor copy of the block's registers and statistics
  logic [9:0]  win_ax, win_bx;
  logic [8:0]  win_ay, win_by;
  logic [7:0]  prec;
  logic [18:0] acc_count;
  logic [63:0] acc_sum[3];
  logic [63:0] acc_sq[3];

  stats_t pending_stats[$];
  int     fail_count;
  int     frames_seen;
  int     pixels_sent;
  bit     rx_idle_on;
  bit     tx_idle_on;
  int     rx_hold;

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  initial begin
    #100_000_000;
    $display("status: fail");
    $finish;
  end

  function automatic logic [63:0] int_sqrt(logic [63:0] a);
    logic [63:0] res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > a) bitv >>= 2;
    while (bitv != 0) begin
      if (a >= res + bitv) begin
        a = a - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  task automatic stats_reset();
    acc_count = 0;
    for (int i = 0; i < 3; i++) begin
      acc_sum[i] = 0;
      acc_sq[i] = 0;
    end
  endtask

  task automatic predict_config(logic [2:0] idx, logic [9:0] d);
    case (idx)
      RegAx:   win_ax = d;
      RegAy:   win_ay = d[8:0];
      RegBx:   win_bx = d;
      RegBy:   win_by = d[8:0];
      RegPrec: prec = d[7:0];
      default: ;
    endcase
  endtask

  task automatic predict_pixel(pixel_t p);
    logic [9:0] x0, x1;
    logic [8:0] y0, y1;
    logic [63:0] ch[3];
    logic [63:0] n, m, q, sd, lo, hi;
    longint t, c;
    stats_t r;
    ch[0] = p.h; ch[1] = p.s; ch[2] = p.v;
    x0 = win_ax < win_bx ? win_ax : win_bx;
    x1 = win_ax < win_bx ? win_bx : win_ax;
    y0 = win_ay < win_by ? win_ay : win_by;
    y1 = win_ay < win_by ? win_by : win_ay;
    if (p.x < ImageWidth && p.y < ImageHeight && p.x >= x0 && p.x <= x1 &&
        p.y >= y0 && p.y <= y1 && acc_count < CountMax) begin
      acc_count++;
      for (int i = 0; i < 3; i++) begin
        acc_sum[i] += ch[i];
        acc_sq[i] += ch[i] * ch[i];
      end
    end
    if (!p.last) return;
    if (acc_count == 0) begin
      for (int i = 0; i < 6; i++) r.thr[i] = 0;
      r.empty = 1;
    end else begin
      n = acc_count;
      for (int i = 0; i < 3; i++) begin
        m = acc_sum[i] / n;
        q = acc_sq[i] + n * m * m - 2 * m * acc_sum[i];
        sd = int_sqrt((q * 256) / n);
        t = longint'(prec) * longint'(sd);
        c = longint'(m * 256);
        lo = (c - t < 0) ? 0 : 64'(c - t) / 16;
        if (c + t > 255 * 256) hi = (i == 0) ? HueClamp : ChanClamp;
        else hi = 64'(c + t) / 16;
        r.thr[2*i] = lo[11:0];
        r.thr[2*i+1] = hi[11:0];
      end
      r.empty = 0;
    end
    pending_stats.push_back(r);
    stats_reset();
  endtask

  // receiver: random stalls, plus a long hold-off when asked
  initial begin
    m_axis_tready = 0;
    @(negedge clk);
    forever begin
      if (rx_hold > 0) begin
        m_axis_tready <= 0;
        repeat (rx_hold) @(negedge clk);
        rx_hold = 0;
      end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 0;
        repeat ($urandom_range(1, 9)) @(negedge clk);
      end else begin
        m_axis_tready <= 1;
        @(negedge clk);
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_stats.size() == 0) begin
        $error("unexpected result beat");
        fail_count++;
      end else begin
        stats_t e;
        e = pending_stats.pop_front();
        frames_seen++;
        for (int i = 0; i < 6; i++)
          if (m_axis_tdata[12*i +: 12] !== e.thr[i]) begin
            $error("threshold %0d: expected %0d, got %0d", i, e.thr[i],
                   m_axis_tdata[12*i +: 12]);
            fail_count++;
          end
        if (m_axis_tuser !== e.empty) begin
          $error("window_empty: expected %0b, got %0b", e.empty, m_axis_tuser);
          fail_count++;
        end
      end
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [9:0] d);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    predict_config(idx, d);
    @(negedge clk);
    cfg_valid <= 0;
    @(negedge clk);
  endtask

  task automatic send_pixel(pixel_t p);
    if (tx_idle_on && $urandom_range(0, 6) == 0) begin
      s_axis_tvalid <= 0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata <= {5'd0, p.v, p.s, p.h, p.y, p.x};
    s_axis_tlast <= p.last;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    predict_pixel(p);
    pixels_sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    s_axis_tvalid <= 0;
    while (pending_stats.size() != 0 && guard < 100000) begin
      @(negedge clk);
      guard++;
    end
    repeat (20) @(negedge clk);
  endtask

  // mostly in-window pixels, some anywhere including off-frame coordinates
  function automatic pixel_t rand_pixel(bit last);
    pixel_t p;
    logic [9:0] x0, x1;
    logic [8:0] y0, y1;
    x0 = win_ax < win_bx ? win_ax : win_bx;
    x1 = win_ax < win_bx ? win_bx : win_ax;
    y0 = win_ay < win_by ? win_ay : win_by;
    y1 = win_ay < win_by ? win_by : win_ay;
    if ($urandom_range(0, 3) != 0) begin
      p.x = 10'($urandom_range(x0, x1));
      p.y = 9'($urandom_range(y0, y1));
    end else begin
      p.x = 10'($urandom);
      p.y = 9'($urandom);
    end
    case ($urandom_range(0, 3))
      0: begin p.h = 8'($urandom); p.s = 8'($urandom); p.v = 8'($urandom); end
      1: begin
        p.h = 8'(200 + $urandom_range(0, 55));
        p.s = 8'($urandom_range(0, 10));
        p.v = 8'(120 + $urandom_range(0, 20));
      end
      default: begin
        p.h = 8'($urandom_range(90, 110));
        p.s = 8'($urandom_range(240, 255));
        p.v = 8'($urandom_range(0, 255));
      end
    endcase
    p.last = last;
    return p;
  endfunction

  cfg_row_t cfg_plan[$];
  pixel_t   dir_rows[$];

  initial begin
    int frame_len;
    rst = 1;
    s_axis_tvalid = 0;
    s_axis_tdata = 0;
    s_axis_tlast = 0;
    cfg_valid = 0;
    cfg_index = 0;
    cfg_data = 0;
    fail_count = 0;
    frames_seen = 0;
    pixels_sent = 0;
    rx_idle_on = 1;
    tx_idle_on = 1;
    rx_hold = 0;
    win_ax = 0; win_ay = 0; win_bx = 0; win_by = 0; prec = 16;
    stats_reset();
    repeat (9) @(negedge clk);
    rst = 0;
    @(negedge clk);

    // directed: reset window is the single pixel (0,0)
    dir_rows = '{
      '{10'd5, 9'd5, 8'd1, 8'd2, 8'd3, 1'b1},          // outside window: empty
      '{10'd0, 9'd0, 8'd255, 8'd255, 8'd255, 1'b1},    // one pixel, sd zero
      '{10'd0, 9'd0, 8'd0, 8'd0, 8'd0, 1'b0},
      '{10'd0, 9'd0, 8'd255, 8'd255, 8'd255, 1'b1}     // clamps the low end
    };
    foreach (dir_rows[i]) send_pixel(dir_rows[i]);
    drain();

    // reversed corners, far corner of the frame, full precision
    cfg_plan = '{'{RegAx, 10'd639}, '{RegAy, 10'd479}, '{RegBx, 10'd600},
                 '{RegBy, 10'd470}, '{RegPrec, 10'd255}};
    foreach (cfg_plan[i]) write_reg(cfg_plan[i].idx, cfg_plan[i].data);
    dir_rows = '{
      '{10'd639, 9'd479, 8'd0, 8'd128, 8'd255, 1'b0},
      '{10'd600, 9'd470, 8'd255, 8'd128, 8'd0, 1'b0},
      '{10'd640, 9'd479, 8'd7, 8'd7, 8'd7, 1'b0},      // off frame x
      '{10'd1023, 9'd511, 8'd7, 8'd7, 8'd7, 1'b0},     // off frame both
      '{10'd620, 9'd475, 8'd100, 8'd50, 8'd10, 1'b1},
      '{10'd599, 9'd475, 8'd9, 8'd9, 8'd9, 1'b1}       // just outside: empty
    };
    foreach (dir_rows[i]) send_pixel(dir_rows[i]);
    drain();
    write_reg(RegPrec, 10'd0);
    write_reg(RegNone, 10'h3FF);                       // unknown index
    send_pixel(pixel_t'{10'd620, 9'd475, 8'd10, 8'd20, 8'd30, 1'b0});
    send_pixel(pixel_t'{10'd630, 9'd471, 8'd90, 8'd80, 8'd70, 1'b1});
    drain();

    // random phases over several window and precision settings
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(RegAx, 10'($urandom_range(0, 639)));
      write_reg(RegAy, 10'($urandom_range(0, 479)));
      write_reg(RegBx, ph == 0 ? 10'd0 : 10'($urandom_range(0, 639)));
      write_reg(RegBy, ph == 0 ? 10'd479 : 10'($urandom_range(0, 479)));
      write_reg(RegPrec, ph == 1 ? 10'd0 :
                (ph == 2 ? 10'd255 : 10'($urandom_range(0, 255))));
      if (ph == 5) begin
        rx_idle_on = 0;
        tx_idle_on = 0;
      end
      for (int f = 0; f < 8; f++) begin
        frame_len = $urandom_range(1, 34);
        if (ph == 3 && f == 0) rx_hold = 800;
        for (int k = 0; k < frame_len; k++) send_pixel(rand_pixel(k == frame_len - 1));
        if (f == 4) drain();                           // sender waits for all results
      end
      drain();
    end

    $display("sent %0d pixel beats, checked %0d result beats", pixels_sent, frames_seen);
    if (fail_count == 0 && pending_stats.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
